### src/tddm_pkg.sv
package tddm_pkg;

   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_CAPTURE = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;

   localparam logic CSR_THRESHOLD   = 1'b0;
   localparam logic CSR_FOUR_SENSOR = 1'b1;

   localparam logic [6:0]  HEAT_MAX    = 7'd90;
   localparam logic [6:0]  DRIFT_LIMIT = 7'd120;
   localparam logic [6:0]  DRIFT_MAX   = 7'd121;
   localparam logic [15:0] HYSTERESIS  = 16'd10;
   localparam logic [3:0]  DERATE_COOL = 4'd10;
   localparam logic [3:0]  DERATE_FLOOR_Q = 4'd5;

   typedef struct packed {
      logic [1:0]       kind;
      logic             sel;
      logic             fresh;
      logic [3:0][15:0] temps;
      logic [1:0][15:0] currents;
      logic [1:0][15:0] voltages;
   } req_type;

   typedef struct packed {
      logic [6:0] cnt;
      logic       trip;
   } drift_state_type;

   // cnt * 205 / 2048 equals cnt / 10 for every 7-bit count
   function automatic logic [3:0] derate_of(input logic [6:0] cnt);
      logic [14:0] prod;
      logic [3:0]  q;
      logic [3:0]  res;
      prod = 15'(cnt) * 15'd205;
      q    = prod[14:11];
      if (cnt == 7'd0) begin
         res = DERATE_COOL;
      end else if (q > DERATE_FLOOR_Q) begin
         res = 4'd0;
      end else begin
         res = 4'd9 - q;
      end
      return res;
   endfunction

endpackage

### src/tddm_channels.sv
interface tddm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        selected_output;
   logic        temps_fresh;
   logic [15:0] temp_one;
   logic [15:0] temp_two;
   logic [15:0] temp_three;
   logic [15:0] temp_four;
   logic [15:0] current_one;
   logic [15:0] current_two;
   logic [15:0] voltage_one;
   logic [15:0] voltage_two;

   modport source (
      output valid, kind, selected_output, temps_fresh, temp_one, temp_two,
             temp_three, temp_four, current_one, current_two, voltage_one,
             voltage_two,
      input  ready
   );
   modport sink (
      input  valid, kind, selected_output, temps_fresh, temp_one, temp_two,
             temp_three, temp_four, current_one, current_two, voltage_one,
             voltage_two,
      output ready
   );
endinterface

interface tddm_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] derate_tenths;
   logic [6:0] heat_count;
   logic       any_uncleared;
   logic       drift_error_one;
   logic       drift_error_two;
   logic       hot_one_a;
   logic       hot_one_b;
   logic       hot_two_a;
   logic       hot_two_b;

   modport source (
      output valid, derate_tenths, heat_count, any_uncleared, drift_error_one,
             drift_error_two, hot_one_a, hot_one_b, hot_two_a, hot_two_b,
      input  ready
   );
   modport sink (
      input  valid, derate_tenths, heat_count, any_uncleared, drift_error_one,
             drift_error_two, hot_one_a, hot_one_b, hot_two_a, hot_two_b,
      output ready
   );
endinterface

### src/tddm_thermal.sv
module tddm_thermal
   import tddm_pkg::*;
(
   input  logic             fresh,
   input  logic             four_mode,
   input  logic [15:0]      threshold,
   input  logic [3:0][15:0] temps,
   input  logic             sel,
   input  logic [3:0]       hot_cur,
   input  logic [1:0][6:0]  heat_cur,
   output logic [3:0]       hot_nxt,
   output logic [1:0][6:0]  heat_nxt
);

   logic [16:0] thr_hi;
   logic        hot_sel;
   logic [6:0]  cnt;

   assign thr_hi = {1'b0, threshold} + {1'b0, HYSTERESIS};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hot_nxt[i] = hot_cur[i];
         if (fresh && (i == 0 || four_mode)) begin
            if (temps[i] < threshold) begin
               hot_nxt[i] = 1'b1;
            end
            if ({1'b0, temps[i]} > thr_hi) begin
               hot_nxt[i] = 1'b0;
            end
         end
      end
   end

   assign hot_sel = sel ? (hot_nxt[2] | hot_nxt[3]) : (hot_nxt[0] | hot_nxt[1]);
   assign cnt     = heat_cur[sel];

   always_comb begin
      heat_nxt = heat_cur;
      if (hot_sel) begin
         if (cnt < HEAT_MAX) begin
            heat_nxt[sel] = cnt + 7'd1;
         end
      end else if (cnt != 7'd0) begin
         heat_nxt[sel] = cnt - 7'd1;
      end
   end

endmodule

### src/tddm_drift.sv
module tddm_drift
   import tddm_pkg::*;
(
   input  logic            enabled,
   input  logic            cool,
   input  logic [15:0]     ref_current,
   input  logic [15:0]     ref_voltage,
   input  logic [15:0]     voltage,
   input  logic [6:0]      cnt_cur,
   output drift_state_type drift_nxt
);

   logic [20:0] v20;
   logic [20:0] r23;
   logic [20:0] r17;
   logic        out_of_band;

   assign v20 = 21'(voltage) * 21'd20;
   assign r23 = 21'(ref_voltage) * 21'd23;
   assign r17 = 21'(ref_voltage) * 21'd17;
   assign out_of_band = (v20 > r23) || (v20 < r17);

   always_comb begin
      if (enabled && cool && ref_current != 16'd0 && out_of_band) begin
         drift_nxt.cnt = (cnt_cur < DRIFT_MAX) ? cnt_cur + 7'd1 : cnt_cur;
      end else begin
         drift_nxt.cnt = 7'd0;
      end
      drift_nxt.trip = drift_nxt.cnt > DRIFT_LIMIT;
   end

endmodule

### src/thermal_derate_drift_monitor.sv
// An accepted transaction is held in the input register; its result is then
// registered in the result register, which waits while the response is not taken.
// Throughput: one transaction per cycle unless stalled; all work is one logic pass.
// Reset: synchronous, active high; clears both stages, all monitor state, sets
// threshold to 0 and four-sensor mode on. No clearing pass is needed.
module thermal_derate_drift_monitor
   import tddm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tddm_req_if.sink    req_ch,
   tddm_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0]     threshold_ff;
   logic            four_mode_ff;

   logic            in_v_ff;
   req_type         in_ff;
   logic            out_v_ff;
   logic            adv;

   logic [3:0]      hot_ff, hot_in;
   logic [1:0][6:0] heat_ff, heat_in;
   logic [1:0][6:0] drift_ff, drift_in;
   logic [1:0][15:0] ref_i_ff, ref_i_in;
   logic [1:0][15:0] ref_v_ff, ref_v_in;
   logic [1:0]      err_ff, err_in;
   logic            unc_ff, unc_in;

   logic [3:0]       hot_tick;
   logic [1:0][6:0]  heat_tick;
   drift_state_type  d0, d1;
   logic             cool0, cool1;

   logic [3:0]  derate_ff;
   logic [6:0]  cnt_ff;
   logic        unc_out_ff;
   logic [1:0]  err_out_ff;
   logic [3:0]  hot_out_ff;

   assign adv          = in_v_ff && (!out_v_ff || rsp_ch.ready);
   assign req_ch.ready = !in_v_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 16'd0;
         four_mode_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD:   threshold_ff <= csr_wdata;
            CSR_FOUR_SENSOR: four_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_ff.kind     <= req_ch.kind;
         in_ff.sel      <= req_ch.selected_output;
         in_ff.fresh    <= req_ch.temps_fresh;
         in_ff.temps    <= {req_ch.temp_four, req_ch.temp_three,
                            req_ch.temp_two, req_ch.temp_one};
         in_ff.currents <= {req_ch.current_two, req_ch.current_one};
         in_ff.voltages <= {req_ch.voltage_two, req_ch.voltage_one};
      end
   end

   tddm_thermal u_thermal (
      .fresh     (in_ff.fresh),
      .four_mode (four_mode_ff),
      .threshold (threshold_ff),
      .temps     (in_ff.temps),
      .sel       (in_ff.sel),
      .hot_cur   (hot_ff),
      .heat_cur  (heat_ff),
      .hot_nxt   (hot_tick),
      .heat_nxt  (heat_tick)
   );

   assign cool0 = !hot_tick[0] && !hot_tick[1] && heat_tick[0] == 7'd0;
   assign cool1 = !hot_tick[2] && !hot_tick[3] && heat_tick[1] == 7'd0;

   tddm_drift u_drift_one (
      .enabled     (1'b1),
      .cool        (cool0),
      .ref_current (ref_i_ff[0]),
      .ref_voltage (ref_v_ff[0]),
      .voltage     (in_ff.voltages[0]),
      .cnt_cur     (drift_ff[0]),
      .drift_nxt   (d0)
   );

   tddm_drift u_drift_two (
      .enabled     (in_ff.sel),
      .cool        (cool1),
      .ref_current (ref_i_ff[1]),
      .ref_voltage (ref_v_ff[1]),
      .voltage     (in_ff.voltages[1]),
      .cnt_cur     (drift_ff[1]),
      .drift_nxt   (d1)
   );

   always_comb begin
      hot_in   = hot_ff;
      heat_in  = heat_ff;
      drift_in = drift_ff;
      ref_i_in = ref_i_ff;
      ref_v_in = ref_v_ff;
      err_in   = err_ff;
      unc_in   = unc_ff;
      case (in_ff.kind)
         KIND_TICK: begin
            hot_in   = hot_tick;
            heat_in  = heat_tick;
            drift_in = {d1.cnt, d0.cnt};
            err_in   = err_ff | {d1.trip, d0.trip};
            unc_in   = unc_ff || heat_tick[in_ff.sel] != 7'd0 || d0.trip || d1.trip;
         end
         KIND_CAPTURE: begin
            ref_i_in = in_ff.currents;
            ref_v_in = in_ff.voltages;
         end
         KIND_CLEAR: begin
            hot_in   = 4'd0;
            err_in   = 2'd0;
            unc_in   = 1'b0;
            ref_i_in = in_ff.currents;
            ref_v_in = in_ff.voltages;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hot_ff   <= 4'd0;
         heat_ff  <= '0;
         drift_ff <= '0;
         ref_i_ff <= '0;
         ref_v_ff <= '0;
         err_ff   <= 2'd0;
         unc_ff   <= 1'b0;
      end else if (adv) begin
         hot_ff   <= hot_in;
         heat_ff  <= heat_in;
         drift_ff <= drift_in;
         ref_i_ff <= ref_i_in;
         ref_v_ff <= ref_v_in;
         err_ff   <= err_in;
         unc_ff   <= unc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         derate_ff  <= derate_of(heat_in[in_ff.sel]);
         cnt_ff     <= heat_in[in_ff.sel];
         unc_out_ff <= unc_in;
         err_out_ff <= err_in;
         hot_out_ff <= hot_in;
      end
   end

   assign rsp_ch.valid           = out_v_ff;
   assign rsp_ch.derate_tenths   = derate_ff;
   assign rsp_ch.heat_count      = cnt_ff;
   assign rsp_ch.any_uncleared   = unc_out_ff;
   assign rsp_ch.drift_error_one = err_out_ff[0];
   assign rsp_ch.drift_error_two = err_out_ff[1];
   assign rsp_ch.hot_one_a       = hot_out_ff[0];
   assign rsp_ch.hot_one_b       = hot_out_ff[1];
   assign rsp_ch.hot_two_a       = hot_out_ff[2];
   assign rsp_ch.hot_two_b       = hot_out_ff[3];

   a_derate_cool: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> ((cnt_ff == 7'd0) == (derate_ff == DERATE_COOL)))
      else $error("derate and heat count disagree");

   a_err_implies_unc: assert property (@(posedge clock) disable iff (reset)
      (err_ff != 2'd0) |-> unc_ff)
      else $error("drift error without uncleared flag");

   a_counter_bounds: assert property (@(posedge clock) disable iff (reset)
      (heat_ff[0] <= HEAT_MAX) && (heat_ff[1] <= HEAT_MAX) &&
      (drift_ff[0] <= DRIFT_MAX) && (drift_ff[1] <= DRIFT_MAX))
      else $error("counter beyond saturation");

endmodule
